@@ src/cnt_pkg.sv @@
// Shared types, widths and constants of the coverage normalize and transfer block.
`default_nettype none

package cnt_pkg;

	localparam int RAW_W      = 8;
	localparam int COV_W      = 8;
	localparam int LVL_W      = 9;
	localparam int STR_W      = 17;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 17;
	localparam int NUM_STAGES = 8;

	typedef logic [RAW_W-1:0]      raw_t;
	typedef logic [COV_W-1:0]      cov_t;
	typedef logic [LVL_W-1:0]      lvl_t;
	typedef logic [STR_W-1:0]      str_t;
	typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GRAY_LEVELS = 1'b0,
		CFG_CURVE_GAIN  = 1'b1
	} cfg_reg_t;

	localparam cov_t COV_MAX   = 8'd255;
	localparam lvl_t LVL_RESET = 9'd256;
	localparam str_t STR_RESET = 17'd0;

	// Half of 65536*255, added before the curve term is divided down.
	localparam logic [31:0] CURVE_HALF = 32'd8355840;

endpackage

`default_nettype wire

@@ src/cnt_intf.sv @@
// Valid/ready channel interfaces for samples, results and configuration writes.
`default_nettype none

interface cnt_sample_if;
	logic            valid;
	logic            ready;
	cnt_pkg::raw_t   raw_level;
	modport source (output valid, output raw_level, input ready);
	modport sink (input valid, input raw_level, output ready);
endinterface

interface cnt_result_if;
	logic            valid;
	logic            ready;
	cnt_pkg::cov_t   coverage_out;
	modport source (output valid, output coverage_out, input ready);
	modport sink (input valid, input coverage_out, output ready);
endinterface

interface cnt_cfg_if;
	logic                valid;
	logic                ready;
	cnt_pkg::cfg_idx_t   index;
	cnt_pkg::cfg_data_t  data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ src/coverage_normalize_transfer.sv @@
// Top level: rescales a coverage sample to 0..255 and applies the contrast curve.
//
//   channel   dir   modport   beat contents
//   sample    in    sink      raw_level (8 bits)
//   result    out   source    coverage_out (8 bits)
//   cfg       in    sink      index (1 bit), data (17 bits); ready is always high
//
// Eight register stages; one sample accepted every cycle unless the result channel stalls the pipeline.
// The rescale divider resolves three, three and two quotient bits in stages two to four;
// the curve product and its divide by 255 take stages five to eight.
// Each stage moves on when it is empty or the one after it moves, so bubbles close up.
// Reset clears valid bits and sets gray_levels to 256 and the curve strength to 0.
`default_nettype none

module coverage_normalize_transfer (
	input  logic          clk,
	input  logic          arst_n,
	cnt_sample_if.sink    sample,
	cnt_result_if.source  result,
	cnt_cfg_if.sink       cfg
);
	import cnt_pkg::*;

	lvl_t gray_levels_q;
	str_t strength_q;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	logic ld1, ld2, ld3, ld4, ld5, ld6, ld7, ld8;

	raw_t        v_s1, v_s2, v_s3;
	logic        byp_s1, byp_s2, byp_s3;
	logic        ovf_s1, ovf_s2, ovf_s3;
	logic [9:0]  den_s1, den_s2, den_s3;
	logic [16:0] rem_s1, rem_s2, rem_s3;
	cov_t        quo_s2, quo_s3;
	cov_t        n_s4, n_s5, n_s6, n_s7;
	logic [13:0] p_s5;
	logic [30:0] m_s6;
	logic [15:0] y_s7;
	cov_t        q0_s7;
	cov_t        cov_s8;

	logic        bypass;
	lvl_t        dmin;
	logic [9:0]  den_c;
	logic [16:0] num_c;
	logic [17:0] lim_c;
	logic [16:0] rem2_c, rem3_c, rem4_c;
	logic [2:0]  qb2_c, qb3_c;
	logic [1:0]  qb4_c;
	cov_t        quo4_c, n4_c;
	logic [15:0] prod5_c;
	logic [31:0] x7_c;
	logic [23:0] y257_c;
	logic [15:0] q255_c, rem8_c;
	cov_t        r8_c;
	logic [8:0]  t8_c;

	// One restoring division step at quotient bit sh; returns {remainder, bit}.
	function automatic logic [17:0] div_step(logic [16:0] rem, logic [9:0] den, int sh);
		logic [16:0] trial;
		trial = {7'b0, den} << sh;
		if (rem >= trial)
			return {rem - trial, 1'b1};
		else
			return {rem, 1'b0};
	endfunction

	// Configuration registers.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gray_levels_q <= LVL_RESET;
			strength_q    <= STR_RESET;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg_reg_t'(cfg.index))
				CFG_GRAY_LEVELS: gray_levels_q <= cfg.data[LVL_W-1:0];
				CFG_CURVE_GAIN:  strength_q    <= cfg.data[STR_W-1:0];
				default: ;
			endcase
		end
	end

	// Stage handshake: a stage loads when it is empty or its successor loads.
	assign ld8 = !vld_s8 || result.ready;
	assign ld7 = !vld_s7 || ld8;
	assign ld6 = !vld_s6 || ld7;
	assign ld5 = !vld_s5 || ld6;
	assign ld4 = !vld_s4 || ld5;
	assign ld3 = !vld_s3 || ld4;
	assign ld2 = !vld_s2 || ld3;
	assign ld1 = !vld_s1 || ld2;
	assign sample.ready = ld1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else begin
			if (ld1) vld_s1 <= sample.valid;
			if (ld2) vld_s2 <= vld_s1;
			if (ld3) vld_s3 <= vld_s2;
			if (ld4) vld_s4 <= vld_s3;
			if (ld5) vld_s5 <= vld_s4;
			if (ld6) vld_s6 <= vld_s5;
			if (ld7) vld_s7 <= vld_s6;
			if (ld8) vld_s8 <= vld_s7;
		end
	end

	// Stage 1: rounded rescale numerator 510*v + d over denominator 2*d.
	always_comb begin
		bypass = (gray_levels_q <= 9'd1) || (gray_levels_q == LVL_RESET);
		dmin   = gray_levels_q - 9'd1;
		den_c  = {dmin, 1'b0};
		num_c  = ({9'b0, sample.raw_level} << 9) - ({9'b0, sample.raw_level} << 1)
		         + {8'b0, dmin};
		lim_c  = {den_c, 8'b0};
	end

	always_ff @(posedge clk) begin
		if (ld1) begin
			v_s1   <= sample.raw_level;
			byp_s1 <= bypass;
			den_s1 <= den_c;
			rem_s1 <= num_c;
			// Quotient of 256 or more saturates.
			ovf_s1 <= {1'b0, num_c} >= lim_c;
		end
	end

	// Stages 2 to 4: quotient bits 7..5, 4..2 and 1..0.
	always_comb begin
		{rem2_c, qb2_c[2]} = div_step(rem_s1, den_s1, 7);
		{rem2_c, qb2_c[1]} = div_step(rem2_c, den_s1, 6);
		{rem2_c, qb2_c[0]} = div_step(rem2_c, den_s1, 5);
		{rem3_c, qb3_c[2]} = div_step(rem_s2, den_s2, 4);
		{rem3_c, qb3_c[1]} = div_step(rem3_c, den_s2, 3);
		{rem3_c, qb3_c[0]} = div_step(rem3_c, den_s2, 2);
		{rem4_c, qb4_c[1]} = div_step(rem_s3, den_s3, 1);
		{rem4_c, qb4_c[0]} = div_step(rem4_c, den_s3, 0);
		quo4_c = {quo_s3[7:2], qb4_c};
		if (byp_s3)
			n4_c = v_s3;
		else if (ovf_s3)
			n4_c = COV_MAX;
		else
			n4_c = quo4_c;
	end

	always_ff @(posedge clk) begin
		if (ld2) begin
			v_s2   <= v_s1;
			byp_s2 <= byp_s1;
			ovf_s2 <= ovf_s1;
			den_s2 <= den_s1;
			rem_s2 <= rem2_c;
			quo_s2 <= {qb2_c, 5'b0};
		end
		if (ld3) begin
			v_s3   <= v_s2;
			byp_s3 <= byp_s2;
			ovf_s3 <= ovf_s2;
			den_s3 <= den_s2;
			rem_s3 <= rem3_c;
			quo_s3 <= {quo_s2[7:5], qb3_c, 2'b0};
		end
		if (ld4)
			n_s4 <= n4_c;
	end

	// Stages 5 to 8: r = round(s*n*(255-n) / (65536*255)), then n + r clamped.
	always_comb begin
		prod5_c = n_s4 * (COV_MAX - n_s4);
		x7_c    = {1'b0, m_s6} + CURVE_HALF;
		// y*257/65536 is the quotient by 255 or one below it.
		y257_c  = {x7_c[31:16], 8'b0} + {8'b0, x7_c[31:16]};
		q255_c  = {q0_s7, 8'b0} - {8'b0, q0_s7};
		rem8_c  = y_s7 - q255_c;
		r8_c    = (rem8_c >= {8'b0, COV_MAX}) ? q0_s7 + 8'd1 : q0_s7;
		t8_c    = {1'b0, n_s7} + {1'b0, r8_c};
	end

	always_ff @(posedge clk) begin
		if (ld5) begin
			n_s5 <= n_s4;
			p_s5 <= prod5_c[13:0];
		end
		if (ld6) begin
			n_s6 <= n_s5;
			m_s6 <= strength_q * p_s5;
		end
		if (ld7) begin
			n_s7  <= n_s6;
			y_s7  <= x7_c[31:16];
			q0_s7 <= y257_c[23:16];
		end
		if (ld8)
			cov_s8 <= (t8_c > {1'b0, COV_MAX}) ? COV_MAX : t8_c[7:0];
	end

	assign result.valid        = vld_s8;
	assign result.coverage_out = cov_s8;

endmodule

`default_nettype wire

@@ src/cnt_checker.sv @@
// Port-level checks of the coverage normalize and transfer block, bound to the top level.
`default_nettype none

module cnt_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_ready,
	input logic          out_valid,
	input logic          out_ready,
	input cnt_pkg::cov_t out_data
);
	import cnt_pkg::*;

	logic [3:0] occ_q;
	logic       acc_in, acc_out;

	assign acc_in  = in_valid && in_ready;
	assign acc_out = out_valid && out_ready;

	// Samples accepted and not yet delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			occ_q <= 4'd0;
		else
			occ_q <= occ_q + {3'b0, acc_in} - {3'b0, acc_out};
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q == 4'd0 |-> !out_valid)
		else $error("result beat with no sample in flight");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= 4'(NUM_STAGES))
		else $error("more samples in flight than pipeline stages");

	a_bubble_ready: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q < 4'(NUM_STAGES) |-> in_ready)
		else $error("sample refused while the pipeline has a free stage");

endmodule

bind coverage_normalize_transfer cnt_checker u_cnt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (sample.valid),
	.in_ready  (sample.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_data  (result.coverage_out)
);

`default_nettype wire
